// File: design/lsa_pkg.sv
// Package for the local sequence aligner: command, base and direction codes,
// configuration register indexes and the controller state type. No dependencies.
package lsa_pkg;

    localparam int CMD_W   = 2;
    localparam int BASE_W  = 3;
    localparam int GAP_W   = 4;
    localparam int SCORE_W = 8;
    localparam int START_W = 10;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADAPTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALIGN   = 2'd2;

    // Codes at or above this one score and gap as N
    localparam logic [BASE_W-1:0] BASE_N = 3'd4;

    // Traceback directions kept per cell
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_DIAG  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_GAP  = 1'b0;
    localparam logic CFG_UNIT = 1'b1;

    localparam logic [SCORE_W-1:0] SCORE_REJECT = 8'hFF;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ROW    = 6'b000010,
        S_CELL   = 6'b000100,
        S_TB_CHK = 6'b001000,
        S_TB_DAT = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

endpackage

// File: design/lsa_if.sv
// Handshake channels of the local sequence aligner: base/command input,
// result output and configuration write. Depends on lsa_pkg.
interface lsa_in_if import lsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BASE_W-1:0] base;
    modport source (output valid, cmd, base, input ready);
    modport sink   (input valid, cmd, base, output ready);
endinterface

interface lsa_out_if import lsa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] score;
    logic [START_W-1:0] read_start;
    logic               found;
    modport source (output valid, score, read_start, found, input ready);
    modport sink   (input valid, score, read_start, found, output ready);
endinterface

interface lsa_cfg_if import lsa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             index;
    logic [GAP_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/lsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module lsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/local_sequence_aligner.sv
// Local sequence aligner top level: base stores, row buffer, score/direction
// matrix memory and the fill/traceback controller. Depends on lsa_pkg,
// lsa_if and lsa_ram.
//
// Usage: the in_ch channel carries one command per transaction. Commands
// append a read base or an adapter base (one per cycle while in_ch is ready,
// bases past capacity are dropped) or start an alignment. An alignment fills
// the local score matrix row by row, one cell per cycle, each row after a
// setup state, then traces back with a check state (S_TB_CHK) and a read
// state (S_TB_DAT) per step (at most read_length + adapter_length steps) and
// grades the match in S_FIN. The fill and the traceback share one matrix
// memory, whose single read port sets the traceback pace. An empty read or
// adapter gives a result in the cycle after the command.
// The result waits in an output register on out_ch; while it is not taken,
// in_ch is held not ready. cfg_ch writes gap_penalty (index 0) and
// col_credit (index 1) at any time and is always ready.
// Reset (synchronous, active low) empties both sequences, sets both
// registers to 1 and drops any pending result. Memories are not cleared.
module local_sequence_aligner import lsa_pkg::*; #(
    parameter int READ_MAX    = 512,
    parameter int ADAPTER_MAX = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lsa_in_if.sink   in_ch,
    lsa_out_if.source out_ch,
    lsa_cfg_if.sink  cfg_ch
);
    localparam int RAW  = READ_MAX > 1 ? $clog2(READ_MAX) : 1;
    localparam int RLW  = $clog2(READ_MAX + 1);
    localparam int AAW  = ADAPTER_MAX > 1 ? $clog2(ADAPTER_MAX) : 1;
    localparam int ALW  = $clog2(ADAPTER_MAX + 1);
    localparam int COLS = ADAPTER_MAX + 1;
    localparam int BD   = ADAPTER_MAX + 2;
    localparam int JW   = $clog2(BD);
    localparam int SW   = $clog2(ADAPTER_MAX + 1);
    localparam int MD   = (READ_MAX + 1) * COLS;
    localparam int MAW  = $clog2(MD);
    localparam int NW   = $clog2(READ_MAX + ADAPTER_MAX + 1);
    localparam int EW   = SW + 6;
    localparam int TW   = NW + 10;

    t_state r_state;
    logic [GAP_W-1:0] r_gap, r_unit;
    logic [RLW-1:0]   r_rlen, r_i, r_bi;
    logic [ALW-1:0]   r_alen, r_bj;
    logic [JW-1:0]    r_j;
    logic [SW-1:0]    r_diag, r_left, r_best;
    logic [MAW-1:0]   r_row_base, r_cell, r_tb_addr;
    logic [NW-1:0]    r_n;
    logic             r_out_valid, r_found;
    logic [SCORE_W-1:0] r_score;
    logic [START_W-1:0] r_read_start;

    logic in_acc;
    logic [BASE_W-1:0] rd_base, ad_base;
    logic [SW-1:0]     buf_up, up;
    logic [SW+1:0]     mx_rdata;
    logic signed [EW-1:0] sub_s, gap_ab, gap_rb, d, dn, rt, mx1, mx2;
    logic [SW-1:0]     m_u;
    logic [1:0]        dir;
    logic              best_hit, last_col, last_row;
    logic signed [TW-1:0] n_s, thr, total_s;
    logic              ok;

    assign in_acc         = in_ch.valid && in_ch.ready;
    assign in_ch.ready    = (r_state == S_IDLE) && !r_out_valid;
    assign cfg_ch.ready   = 1'b1;
    assign out_ch.valid      = r_out_valid;
    assign out_ch.score      = r_score;
    assign out_ch.read_start = r_read_start;
    assign out_ch.found      = r_found;

    // Sequence stores
    lsa_ram #(.WIDTH(BASE_W), .DEPTH(READ_MAX)) u_read_ram (
        .i_clk  (i_clk),
        .i_we   (in_acc && in_ch.cmd == CMD_READ && r_rlen < RLW'(READ_MAX)),
        .i_waddr(RAW'(r_rlen)),
        .i_wdata(in_ch.base),
        .i_raddr(RAW'(r_i - RLW'(1))),
        .o_rdata(rd_base)
    );

    lsa_ram #(.WIDTH(BASE_W), .DEPTH(ADAPTER_MAX)) u_adapter_ram (
        .i_clk  (i_clk),
        .i_we   (in_acc && in_ch.cmd == CMD_ADAPTER && r_alen < ALW'(ADAPTER_MAX)),
        .i_waddr(AAW'(r_alen)),
        .i_wdata(in_ch.base),
        .i_raddr(AAW'(r_state == S_CELL ? r_j : r_j - JW'(1))),
        .o_rdata(ad_base)
    );

    // Previous-row scores; read ahead one column while writing the current one
    lsa_ram #(.WIDTH(SW), .DEPTH(BD)) u_row_buf (
        .i_clk  (i_clk),
        .i_we   (r_state == S_CELL),
        .i_waddr(r_j),
        .i_wdata(m_u),
        .i_raddr(r_state == S_CELL ? r_j + JW'(1) : r_j),
        .o_rdata(buf_up)
    );

    // Score and direction of every cell, for the traceback
    lsa_ram #(.WIDTH(SW + 2), .DEPTH(MD)) u_matrix (
        .i_clk  (i_clk),
        .i_we   (r_state == S_CELL),
        .i_waddr(r_cell),
        .i_wdata({m_u, dir}),
        .i_raddr(r_tb_addr),
        .o_rdata(mx_rdata)
    );

    // Cell update: max of diagonal, down, right and zero
    always_comb begin
        up = (r_i == RLW'(1)) ? '0 : buf_up;
        if (rd_base >= BASE_N || ad_base >= BASE_N) begin
            sub_s = '0;
        end else if (rd_base == ad_base) begin
            sub_s = EW'(1);
        end else begin
            sub_s = -EW'(1);
        end
        gap_ab = (ad_base >= BASE_N) ? '0 : $signed({{(EW-GAP_W){1'b0}}, r_gap});
        gap_rb = (rd_base >= BASE_N) ? '0 : $signed({{(EW-GAP_W){1'b0}}, r_gap});
        d   = $signed({{(EW-SW){1'b0}}, r_diag}) + sub_s;
        dn  = $signed({{(EW-SW){1'b0}}, up}) - gap_ab;
        rt  = $signed({{(EW-SW){1'b0}}, r_left}) - gap_rb;
        mx1 = (d >= dn) ? d : dn;
        mx2 = (mx1 >= rt) ? mx1 : rt;
        if (mx2 < 0) begin
            mx2 = '0;
        end
        m_u = mx2[SW-1:0];
        if (mx2 == d) begin
            dir = DIR_DIAG;
        end else if (mx2 == dn) begin
            dir = DIR_DOWN;
        end else if (mx2 == rt) begin
            dir = DIR_RIGHT;
        end else begin
            dir = DIR_NONE;
        end
        best_hit = m_u >= r_best;
        last_col = r_j == JW'(r_alen);
        last_row = r_i == r_rlen;
    end

    // Acceptance threshold: (n - 2) * col_credit - 2 * gap_penalty
    always_comb begin
        n_s     = $signed({{(TW-NW){1'b0}}, r_n}) - TW'(2);
        thr     = n_s * $signed({{(TW-GAP_W){1'b0}}, r_unit})
                  - $signed({{(TW-GAP_W-1){1'b0}}, r_gap, 1'b0});
        total_s = $signed({{(TW-SW){1'b0}}, r_best});
        ok      = !(total_s <= thr || r_bj != '0);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap  <= GAP_W'(1);
            r_unit <= GAP_W'(1);
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                CFG_GAP:  r_gap  <= cfg_ch.data;
                CFG_UNIT: r_unit <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    // Controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rlen      <= '0;
            r_alen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (in_ch.cmd)
                            CMD_READ: begin
                                if (r_rlen < RLW'(READ_MAX)) r_rlen <= r_rlen + RLW'(1);
                            end
                            CMD_ADAPTER: begin
                                if (r_alen < ALW'(ADAPTER_MAX)) r_alen <= r_alen + ALW'(1);
                            end
                            CMD_ALIGN: begin
                                if (r_rlen == '0 || r_alen == '0) begin
                                    r_score      <= SCORE_REJECT;
                                    r_read_start <= '0;
                                    r_found      <= 1'b0;
                                    r_out_valid  <= 1'b1;
                                    r_rlen       <= '0;
                                    r_alen       <= '0;
                                end else begin
                                    r_i        <= RLW'(1);
                                    r_j        <= JW'(1);
                                    r_row_base <= MAW'(COLS);
                                    r_best     <= '0;
                                    r_bi       <= '0;
                                    r_bj       <= '0;
                                    r_tb_addr  <= '0;
                                    r_n        <= '0;
                                    r_state    <= S_ROW;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ROW: begin
                    r_diag  <= '0;
                    r_left  <= '0;
                    r_cell  <= r_row_base + MAW'(1);
                    r_state <= S_CELL;
                end
                S_CELL: begin
                    r_diag <= up;
                    r_left <= m_u;
                    r_cell <= r_cell + MAW'(1);
                    if (best_hit) begin
                        r_best    <= m_u;
                        r_bi      <= r_i;
                        r_bj      <= ALW'(r_j);
                        r_tb_addr <= r_cell;
                    end
                    if (last_col) begin
                        r_j <= JW'(1);
                        if (last_row) begin
                            r_state <= S_TB_CHK;
                        end else begin
                            r_i        <= r_i + RLW'(1);
                            r_row_base <= r_row_base + MAW'(COLS);
                            r_state    <= S_ROW;
                        end
                    end else begin
                        r_j <= r_j + JW'(1);
                    end
                end
                S_TB_CHK: begin
                    r_state <= (r_bi == '0 || r_bj == '0) ? S_FIN : S_TB_DAT;
                end
                S_TB_DAT: begin
                    if (mx_rdata[SW+1:2] == '0 || mx_rdata[1:0] == DIR_NONE) begin
                        r_state <= S_FIN;
                    end else begin
                        case (mx_rdata[1:0])
                            DIR_DIAG: begin
                                r_bi      <= r_bi - RLW'(1);
                                r_bj      <= r_bj - ALW'(1);
                                r_tb_addr <= r_tb_addr - MAW'(COLS + 1);
                            end
                            DIR_RIGHT: begin
                                r_bj      <= r_bj - ALW'(1);
                                r_tb_addr <= r_tb_addr - MAW'(1);
                            end
                            default: begin
                                r_bi      <= r_bi - RLW'(1);
                                r_tb_addr <= r_tb_addr - MAW'(COLS);
                            end
                        endcase
                        r_n     <= r_n + NW'(1);
                        r_state <= S_TB_CHK;
                    end
                end
                S_FIN: begin
                    r_score      <= ok ? SCORE_W'(r_best) : SCORE_REJECT;
                    r_read_start <= START_W'(r_bi);
                    r_found      <= ok;
                    r_out_valid  <= 1'b1;
                    r_rlen       <= '0;
                    r_alen       <= '0;
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_cell_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CELL |-> (r_i != '0 && r_i <= r_rlen && r_j != '0
                               && r_j <= JW'(r_alen)))
        else $error("fill cell outside the loaded sequences");

    a_fin_posts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |=> (r_out_valid && r_state == S_IDLE))
        else $error("grading did not post a result");

    a_tb_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TB_DAT |-> $past(r_state) == S_TB_CHK)
        else $error("traceback data used without a read");

    a_found_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && ok) |-> r_bj == '0)
        else $error("accepted match does not start at adapter base 0");
endmodule

// File: dv/tb_local_sequence_aligner.sv
// Self-checking testbench for local_sequence_aligner: directed and random base loading,
// alignments, configuration sweeps and output back-pressure, checked against a local predictor.
// Depends on lsa_pkg, the lsa_if interfaces and the local_sequence_aligner RTL.
module tb_local_sequence_aligner;
    import lsa_pkg::*;

    localparam int READ_CAP  = 512;
    localparam int ADPT_CAP  = 64;
    localparam int LIMIT     = 1500000;
    localparam int SETTLE    = 40;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [START_W-1:0] read_start;
        logic               found;
    } t_match;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lsa_in_if  in_ch();
    lsa_out_if out_ch();
    lsa_cfg_if cfg_ch();

    local_sequence_aligner uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state
    logic [3:0]        gap_pen = 4'd1;
    logic [3:0]        unit_sc = 4'd1;
    logic [BASE_W-1:0] read_seq [READ_CAP];
    logic [BASE_W-1:0] adpt_seq [ADPT_CAP];
    int                read_len = 0;
    int                adpt_len = 0;
    int                cell_score [0:READ_CAP][0:ADPT_CAP];
    logic [1:0]        cell_dir   [0:READ_CAP][0:ADPT_CAP];

    t_match expected_matches[$];
    int     mismatches = 0;
    int     cyc = 0;
    int     burst_left = 0;
    bit     no_gaps = 0;
    int     hold_asked = 0;
    int     hold_done = 0;

    function automatic int base_pair_score(logic [2:0] a, logic [2:0] b);
        if (a >= BASE_N || b >= BASE_N) return 0;
        return (a == b) ? 1 : -1;
    endfunction

    function automatic int gap_against(logic [2:0] opp);
        return (opp >= BASE_N) ? 0 : int'(gap_pen);
    endfunction

    // Fill the local score matrix, trace back and grade the match
    function automatic t_match align_predict();
        t_match r;
        int best, bi, bj, d, dn, rt, m, cur, n;
        bit ok;
        best = -1; bi = 0; bj = 0; n = 0;
        if (read_len == 0 || adpt_len == 0) begin
            r.score = SCORE_REJECT; r.read_start = '0; r.found = 1'b0;
            return r;
        end
        for (int j = 0; j <= adpt_len; j++) cell_score[0][j] = 0;
        for (int i = 0; i <= read_len; i++) cell_score[i][0] = 0;
        for (int i = 1; i <= read_len; i++) begin
            for (int j = 1; j <= adpt_len; j++) begin
                d  = cell_score[i-1][j-1] + base_pair_score(read_seq[i-1], adpt_seq[j-1]);
                dn = cell_score[i-1][j] - gap_against(adpt_seq[j-1]);
                rt = cell_score[i][j-1] - gap_against(read_seq[i-1]);
                m = (d >= dn) ? d : dn;
                m = (m >= rt) ? m : rt;
                if (m < 0) m = 0;
                if (m == d) cell_dir[i][j] = DIR_DIAG;
                else if (m == dn) cell_dir[i][j] = DIR_DOWN;
                else if (m == rt) cell_dir[i][j] = DIR_RIGHT;
                else cell_dir[i][j] = DIR_NONE;
                cell_score[i][j] = m;
                if (m >= best) begin
                    best = m; bi = i; bj = j;
                end
            end
        end
        cur = best;
        while (cur != 0 && bi > 0 && bj > 0) begin
            if (cell_dir[bi][bj] == DIR_DIAG) begin
                bi--; bj--;
            end else if (cell_dir[bi][bj] == DIR_RIGHT) begin
                bj--;
            end else if (cell_dir[bi][bj] == DIR_DOWN) begin
                bi--;
            end else begin
                break;
            end
            cur = cell_score[bi][bj];
            n++;
        end
        ok = !(best <= (n - 2) * int'(unit_sc) - 2 * int'(gap_pen) || bj != 0);
        r.score = ok ? SCORE_W'(best) : SCORE_REJECT;
        r.read_start = START_W'(bi);
        r.found = ok;
        return r;
    endfunction

    // Send one command transaction; sender sends in bursts with idle gaps unless no_gaps is set
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [BASE_W-1:0] b);
        if (!no_gaps && burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= c;
        in_ch.base  <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        case (c)
            CMD_READ: begin
                if (read_len < READ_CAP) begin
                    read_seq[read_len] = b; read_len++;
                end
            end
            CMD_ADAPTER: begin
                if (adpt_len < ADPT_CAP) begin
                    adpt_seq[adpt_len] = b; adpt_len++;
                end
            end
            CMD_ALIGN: begin
                expected_matches.push_back(align_predict());
                read_len = 0; adpt_len = 0;
            end
            default: ;
        endcase
    endtask

    task automatic go_quiet();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register write, only once the block has drained
    task automatic write_cfg(input logic idx, input logic [GAP_W-1:0] val);
        go_quiet();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_GAP) gap_pen = val;
        else unit_sc = val;
    endtask

    function automatic logic [2:0] pick_base();
        return ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 3))
                                            : 3'($urandom_range(4, 7));
    endfunction

    // One well-formed job: adapter, read with the adapter head planted in it, align
    task automatic run_job(input int rlen, input int alen);
        logic [2:0] ad [$];
        int pos, plant;
        for (int j = 0; j < alen; j++) begin
            ad.push_back(pick_base());
            send_item(CMD_ADAPTER, ad[j]);
        end
        pos = $urandom_range(0, rlen);
        plant = $urandom_range(0, alen);
        for (int i = 0; i < rlen; i++) begin
            if (i >= pos && i - pos < plant && i - pos < alen && $urandom_range(0, 9) != 0)
                send_item(CMD_READ, ad[i - pos]);
            else
                send_item(CMD_READ, pick_base());
        end
        send_item(CMD_ALIGN, 3'($urandom_range(0, 7)));
    endtask

    // Result checker and receiver stall pattern
    int stall_pct = 0;
    int phase_left = 0;
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_matches.size() == 0) begin
                    $display("%0t: unexpected result score=%0d start=%0d found=%0b", $time,
                             $signed(out_ch.score), out_ch.read_start, out_ch.found);
                    mismatches++;
                end else begin
                    t_match e;
                    e = expected_matches.pop_front();
                    if (e.score !== out_ch.score) begin
                        $display("%0t: score expected %0d actual %0d", $time,
                                 $signed(e.score), $signed(out_ch.score));
                        mismatches++;
                    end
                    if (e.read_start !== out_ch.read_start) begin
                        $display("%0t: read_start expected %0d actual %0d", $time,
                                 e.read_start, out_ch.read_start);
                        mismatches++;
                    end
                    if (e.found !== out_ch.found) begin
                        $display("%0t: found expected %0b actual %0b", $time,
                                 e.found, out_ch.found);
                        mismatches++;
                    end
                end
            end
            if (hold_cnt == 0 && hold_done < hold_asked) begin
                hold_done++;
                hold_cnt = 400;
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 120);
                case ($urandom_range(0, 3))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 30;
                    default: stall_pct = 70;
                endcase
            end
            phase_left--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic test_empty();
        send_item(CMD_ALIGN, 3'd0);
        send_item(CMD_READ, 3'd2);
        send_item(CMD_ALIGN, 3'd7);
        send_item(CMD_ADAPTER, 3'd1);
        send_item(CMD_ALIGN, 3'd0);
    endtask

    task automatic test_directed();
        // exact match at adapter start
        send_item(CMD_ADAPTER, 3'd0); send_item(CMD_ADAPTER, 3'd1);
        send_item(CMD_ADAPTER, 3'd2); send_item(CMD_ADAPTER, 3'd3);
        send_item(CMD_READ, 3'd3); send_item(CMD_READ, 3'd0); send_item(CMD_READ, 3'd1);
        send_item(CMD_READ, 3'd2); send_item(CMD_READ, 3'd3);
        send_item(CMD_ALIGN, 3'd0);
        // N and codes above N, unused command in between
        send_item(CMD_ADAPTER, 3'd4); send_item(CMD_ADAPTER, 3'd7);
        send_item(2'd3, 3'd5);
        send_item(CMD_READ, 3'd6); send_item(CMD_READ, 3'd5); send_item(CMD_READ, 3'd0);
        send_item(CMD_ALIGN, 3'd0);
        // all mismatches: zero best score
        send_item(CMD_ADAPTER, 3'd0); send_item(CMD_READ, 3'd1); send_item(CMD_READ, 3'd2);
        send_item(CMD_ALIGN, 3'd0);
    endtask

    task automatic test_capacity();
        for (int j = 0; j < ADPT_CAP + 2; j++) send_item(CMD_ADAPTER, 3'(j % 4));
        for (int i = 0; i < READ_CAP + 2; i++)
            send_item(CMD_READ, (i >= 100 && i < 164) ? 3'((i - 100) % 4) : pick_base());
        send_item(CMD_ALIGN, 3'd0);
    endtask

    task automatic test_config_sweep();
        logic [3:0] vals [4] = '{4'd0, 4'd15, 4'd3, 4'd1};
        foreach (vals[k]) begin
            write_cfg(CFG_GAP, vals[k]);
            write_cfg(CFG_UNIT, vals[3 - k]);
            repeat (4) run_job($urandom_range(1, 24), $urandom_range(1, 10));
        end
    endtask

    task automatic test_backpressure();
        hold_asked++;
        repeat (6) run_job($urandom_range(1, 6), $urandom_range(1, 3));
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 350) begin
            int r, a;
            if ($urandom_range(0, 14) == 0) begin
                write_cfg(CFG_GAP, 4'($urandom_range(0, 15)));
                write_cfg(CFG_UNIT, 4'($urandom_range(0, 15)));
            end
            no_gaps = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    // noise: any command, any base
                    repeat (4) send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
                    sent += 4;
                end
                1: begin
                    r = $urandom_range(0, 3);
                    a = $urandom_range(0, 2);
                    run_job(r, a);
                    sent += r + a + 1;
                end
                default: begin
                    r = $urandom_range(1, 30);
                    a = $urandom_range(1, 12);
                    run_job(r, a);
                    sent += r + a + 1;
                end
            endcase
        end
        no_gaps = 0;
    endtask

    initial begin
        in_ch.valid = 1'b0; in_ch.cmd = CMD_READ; in_ch.base = '0;
        cfg_ch.valid = 1'b0; cfg_ch.index = CFG_GAP; cfg_ch.data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty();
        test_directed();
        test_capacity();
        test_backpressure();
        test_config_sweep();
        test_random();
        go_quiet();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_matches.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: filelist.f
design/lsa_pkg.sv
design/lsa_if.sv
design/lsa_ram.sv
design/local_sequence_aligner.sv
dv/tb_local_sequence_aligner.sv
